FILE: rtl/cisu_pkg.sv
// shared types and constants for the contact/ising site update block
// no dependencies
package cisu_pkg;

  localparam int unsigned LatticeSide = 256;
  localparam int unsigned CoordW      = $clog2(LatticeSide);
  localparam int unsigned AddrW       = 2 * CoordW;
  localparam int unsigned SiteTotal   = LatticeSide * LatticeSide;
  localparam int unsigned CntW        = 17;
  localparam int unsigned QOne        = 65536;

  localparam logic [1:0] SiteEmpty = 2'd0;
  localparam logic [1:0] SiteOcc   = 2'd1;
  localparam logic [1:0] SiteUp    = 2'd2;
  localparam logic [1:0] SiteDown  = 2'd3;

  localparam logic [2:0] RegBirth  = 3'd0;
  localparam logic [2:0] RegDeath  = 3'd1;
  localparam logic [2:0] RegDiff   = 3'd2;
  localparam logic [2:0] RegRatio  = 3'd3;
  localparam logic [2:0] RegCoupl  = 3'd4;
  localparam logic [2:0] RegRadius = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  site_x;
    logic [7:0]  site_y;
    logic [4:0]  neighbour_pick;
    logic [15:0] draw_birth;
    logic [15:0] draw_death;
    logic [15:0] draw_differentiate;
    logic        spin_choice;
    logic [15:0] draw_flip;
  } item_in_t;

  typedef struct packed {
    logic [1:0]      new_site_state;
    logic            site_changed;
    logic [CntW-1:0] occupied_total;
    logic [CntW-1:0] up_total;
    logic [CntW-1:0] down_total;
  } item_out_t;

endpackage

FILE: rtl/contact_ising_site_update.sv
// contact process / ising site update on a toroidal lattice held in one ram
// depends on cisu_pkg
// init: busy for one clearing write per cycle over all sites, then the seed write,
//   strobe in the cycle after; update, N = 8 or 24 neighbours: reads of the focal site,
//   its N neighbours, an energy state, |E| multiplies if E < 0 (|E| <= N), write-back
// one beat at a time, next start taken in the strobe cycle at the earliest;
//   the receiver cannot stall
// reset clears control and counts, presets config; the lattice is undefined until init
module contact_ising_site_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cisu_pkg::item_in_t   item_i,
  output logic                 valid_o,
  output cisu_pkg::item_out_t  result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StPow   = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;
  localparam logic [2:0] StEng   = 3'd5;

  localparam int unsigned SiteTotalC = cisu_pkg::SiteTotal;
  localparam int unsigned CntIdxW = $clog2(SiteTotalC + 1);

  // configuration registers
  logic [16:0] birth_q, death_q, diff_q;
  logic [15:0] ratio_q;
  logic [1:0]  coupl_q, radius_q;

  assign pready = 1'b1;
  wire cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q  <= 17'd65536;
      death_q  <= 17'd0;
      diff_q   <= 17'd6554;
      ratio_q  <= 16'd0;
      coupl_q  <= 2'b11;
      radius_q <= 2'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        cisu_pkg::RegBirth:  birth_q  <= pwdata[16:0];
        cisu_pkg::RegDeath:  death_q  <= pwdata[16:0];
        cisu_pkg::RegDiff:   diff_q   <= pwdata[16:0];
        cisu_pkg::RegRatio:  ratio_q  <= pwdata[15:0];
        cisu_pkg::RegCoupl:  coupl_q  <= pwdata[1:0];
        cisu_pkg::RegRadius: radius_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      cisu_pkg::RegBirth:  prdata = {15'd0, birth_q};
      cisu_pkg::RegDeath:  prdata = {15'd0, death_q};
      cisu_pkg::RegDiff:   prdata = {15'd0, diff_q};
      cisu_pkg::RegRatio:  prdata = {16'd0, ratio_q};
      cisu_pkg::RegCoupl:  prdata = {30'd0, coupl_q};
      cisu_pkg::RegRadius: prdata = {30'd0, radius_q};
      default:             prdata = 32'd0;
    endcase
  end

  // lattice memory, one read and one write port, registered read data
  logic [1:0] lattice_mem [SiteTotalC];
  logic [1:0] rd_data_q;
  logic [cisu_pkg::AddrW-1:0] rd_addr, wr_addr;
  logic [1:0] wr_data;
  logic       wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) lattice_mem[wr_addr] <= wr_data;
    rd_data_q <= lattice_mem[rd_addr];
  end

  // control
  logic [2:0] state_q, state_d;
  cisu_pkg::item_in_t item_q;
  logic [CntIdxW-1:0] clr_q;     // clearing address, top value marks seed step
  logic [4:0] rd_idx_q;           // read sequence index: 0 focal, 1..N neighbours
  logic       rd_vld_q;           // read data of previous index arrives this cycle
  logic [4:0] rd_prev_q;
  logic [1:0] cur_q, picked_q;
  logic signed [5:0] sum_q;
  logic [4:0] pow_left_q;
  logic [16:0] p_q;
  logic [cisu_pkg::CntW-1:0] occ_q, up_q, dn_q;
  logic       valid_q;
  cisu_pkg::item_out_t res_q;

  // effective radius and neighbour count
  wire        rad2  = radius_q[1];
  wire [4:0]  ncount = rad2 ? 5'd24 : 5'd8;
  wire [4:0]  pick_c = (item_q.neighbour_pick > ncount - 5'd1) ? ncount - 5'd1
                                                              : item_q.neighbour_pick;

  // neighbour offsets for a sequence index (1-based over the list, centre skipped)
  // column and row of the square come from compares against the column starts
  logic signed [2:0] off_i, off_j;
  always_comb begin
    logic [4:0] k;
    logic [4:0] side;
    logic [4:0] pos;
    logic [4:0] col;
    logic [4:0] row;
    logic [4:0] radv;
    k    = rd_idx_q - 5'd1;
    side = rad2 ? 5'd5 : 5'd3;
    radv = rad2 ? 5'd2 : 5'd1;
    pos  = (k >= ((side * side) >> 1)) ? k + 5'd1 : k;
    if (rad2) begin
      col = (pos >= 5'd20) ? 5'd4 : (pos >= 5'd15) ? 5'd3 : (pos >= 5'd10) ? 5'd2 :
            (pos >= 5'd5) ? 5'd1 : 5'd0;
    end else begin
      col = (pos >= 5'd6) ? 5'd2 : (pos >= 5'd3) ? 5'd1 : 5'd0;
    end
    row   = pos - col * side;
    off_i = 3'(col - radv);
    off_j = 3'(row - radv);
  end

  wire [7:0] nx = item_q.site_x + 8'(signed'(off_i));
  wire [7:0] ny = item_q.site_y + 8'(signed'(off_j));

  always_comb begin
    rd_addr = {item_q.site_y, item_q.site_x};
    if (rd_idx_q != 5'd0) rd_addr = {ny, nx};
  end

  // decision once all reads are in
  wire signed [2:0] jv = (coupl_q == 2'b00) ? 3'sd0 : (coupl_q == 2'b01) ? 3'sd1 : -3'sd1;
  wire signed [2:0] sv = (cur_q == cisu_pkg::SiteUp) ? 3'sd1 : -3'sd1;
  wire signed [7:0] energy = 8'(jv * sv) * 8'(sum_q);
  wire [33:0] prod = p_q * ratio_q;

  logic [1:0] nxt;
  logic [cisu_pkg::CntW-1:0] occ_d, up_d, dn_d;
  always_comb begin
    logic flip;
    nxt = cur_q; occ_d = occ_q; up_d = up_q; dn_d = dn_q;
    flip = (energy > 0) || ({1'b0, item_q.draw_flip} < p_q);
    case (cur_q)
      cisu_pkg::SiteEmpty: begin
        if ({1'b0, item_q.draw_birth} < birth_q && picked_q != cisu_pkg::SiteEmpty) begin
          nxt = picked_q; occ_d = occ_q + 1'b1;
          if (picked_q == cisu_pkg::SiteUp)   up_d = up_q + 1'b1;
          if (picked_q == cisu_pkg::SiteDown) dn_d = dn_q + 1'b1;
        end
      end
      cisu_pkg::SiteOcc: begin
        if ({1'b0, item_q.draw_death} < death_q) begin
          nxt = cisu_pkg::SiteEmpty; occ_d = occ_q - 1'b1;
        end else if ({1'b0, item_q.draw_differentiate} < diff_q) begin
          if (!item_q.spin_choice) begin nxt = cisu_pkg::SiteUp; up_d = up_q + 1'b1; end
          else begin nxt = cisu_pkg::SiteDown; dn_d = dn_q + 1'b1; end
        end
      end
      default: begin
        if ({1'b0, item_q.draw_death} < death_q) begin
          nxt = cisu_pkg::SiteEmpty; occ_d = occ_q - 1'b1;
          if (cur_q == cisu_pkg::SiteUp) up_d = up_q - 1'b1;
          else dn_d = dn_q - 1'b1;
        end else if (flip) begin
          if (cur_q == cisu_pkg::SiteUp) begin
            nxt = cisu_pkg::SiteDown; up_d = up_q - 1'b1; dn_d = dn_q + 1'b1;
          end else begin
            nxt = cisu_pkg::SiteUp; dn_d = dn_q - 1'b1; up_d = up_q + 1'b1;
          end
        end
      end
    endcase
  end

  wire accept = start && !busy;
  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = {item_q.site_y, item_q.site_x};
    wr_data = nxt;
    unique case (state_q)
      StIdle:  if (accept) state_d = item_i.cmd ? StClear : StRead;
      StClear: begin
        wr_en = 1'b1;
        if (clr_q == CntIdxW'(SiteTotalC)) begin
          wr_addr = {8'(cisu_pkg::LatticeSide / 2), 8'(cisu_pkg::LatticeSide / 2)};
          wr_data = cisu_pkg::SiteOcc;
          state_d = StIdle;
        end else begin
          wr_addr = clr_q[cisu_pkg::AddrW-1:0];
          wr_data = cisu_pkg::SiteEmpty;
        end
      end
      StRead:  if (rd_vld_q && rd_prev_q == ncount) state_d = StEng;
      StEng:   state_d = StPow;
      StPow:   if (pow_left_q == 5'd0) state_d = StWrite;
      StWrite: begin
        wr_en   = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      clr_q <= '0; rd_idx_q <= '0; rd_vld_q <= 1'b0; rd_prev_q <= '0;
      occ_q <= '0; up_q <= '0; dn_q <= '0;
      valid_q <= 1'b0; sum_q <= '0; pow_left_q <= '0;
      cur_q <= '0; picked_q <= '0; p_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == StWrite)
                 || (state_q == StClear && clr_q == CntIdxW'(SiteTotalC));
      rd_vld_q <= (state_q == StRead) && (rd_idx_q <= ncount);
      unique case (state_q)
        StIdle: if (accept) begin
          clr_q <= '0; rd_idx_q <= '0; sum_q <= '0;
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CntIdxW'(SiteTotalC)) begin
            occ_q <= 17'd1; up_q <= '0; dn_q <= '0;
            res_q <= '{new_site_state: cisu_pkg::SiteOcc, site_changed: 1'b0,
                       occupied_total: 17'd1, up_total: '0, down_total: '0};
          end
        end
        StRead: begin
          if (rd_idx_q <= ncount) begin
            rd_prev_q <= rd_idx_q; rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (rd_prev_q == 5'd0) cur_q <= rd_data_q;
            else begin
              if (rd_prev_q - 5'd1 == pick_c) picked_q <= rd_data_q;
              if (rd_data_q == cisu_pkg::SiteUp)   sum_q <= sum_q + 6'sd1;
              if (rd_data_q == cisu_pkg::SiteDown) sum_q <= sum_q - 6'sd1;
            end
          end
        end
        StEng: begin
          // power count is -E when E is negative, else no multiplies
          pow_left_q <= (energy < 8'sd0) ? 5'(-energy) : 5'd0;
          p_q <= 17'(cisu_pkg::QOne);
        end
        StPow: begin
          if (pow_left_q != 5'd0) begin
            pow_left_q <= pow_left_q - 1'b1;
            p_q <= prod[32:16];
          end
        end
        StWrite: begin
          occ_q <= occ_d; up_q <= up_d; dn_q <= dn_d;
          res_q <= '{new_site_state: nxt, site_changed: nxt != cur_q,
                     occupied_total: occ_d, up_total: up_d, down_total: dn_d};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

FILE: rtl/cisu_checker.sv
// port-level checker for contact_ising_site_update, bound to the top level
// depends on cisu_pkg
module cisu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input cisu_pkg::item_out_t result_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("no busy after accept");
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("strobe longer than one cycle");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result while busy");
  a_init_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.new_site_state == cisu_pkg::SiteOcc && !result_o.site_changed
    && result_o.up_total == '0 && result_o.down_total == '0 |-> result_o.occupied_total != '0)
    else $error("occupied site with zero count");
endmodule

bind contact_ising_site_update cisu_checker u_cisu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .valid_o(valid_o), .result_o(result_o));

FILE: verif/tb_top.sv
// self-checking bench for contact_ising_site_update: lattice predictor, command driver, apb writes
// depends on cisu_pkg and the rtl top level
`timescale 1ns / 1ps

// predicts every beat from a private copy of the lattice and registers
class site_ledger;
  bit [1:0]                  sites [cisu_pkg::SiteTotal];
  bit [cisu_pkg::CntW-1:0]   occ_n, up_n, down_n;
  bit [16:0]                 birth_p, death_p, diff_p;
  bit [15:0]                 ratio;
  bit [1:0]                  coupling_bits;
  bit [1:0]                  radius_bits;
  cisu_pkg::item_out_t       expected_q[$];
  int                        errors;

  function new();
    occ_n = '0; up_n = '0; down_n = '0;
    birth_p = 17'd65536; death_p = '0; diff_p = 17'd6554;
    ratio = '0; coupling_bits = 2'b11; radius_bits = 2'd1;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      cisu_pkg::RegBirth:  birth_p = val[16:0];
      cisu_pkg::RegDeath:  death_p = val[16:0];
      cisu_pkg::RegDiff:   diff_p = val[16:0];
      cisu_pkg::RegRatio:  ratio = val[15:0];
      cisu_pkg::RegCoupl:  coupling_bits = val[1:0];
      cisu_pkg::RegRadius: radius_bits = val[1:0];
      default: ;
    endcase
  endfunction

  function void note_item(cisu_pkg::item_in_t it);
    cisu_pkg::item_out_t res;
    bit [1:0]  cur, nxt, picked, v;
    int        rad, pick, idx, spin_sum, jc, s, e, k;
    longint    p;
    bit        flip;
    if (it.cmd) begin
      foreach (sites[n]) sites[n] = cisu_pkg::SiteEmpty;
      sites[(cisu_pkg::LatticeSide / 2) * cisu_pkg::LatticeSide
            + cisu_pkg::LatticeSide / 2] = cisu_pkg::SiteOcc;
      occ_n = 17'd1; up_n = '0; down_n = '0;
      res.new_site_state = cisu_pkg::SiteOcc;
      res.site_changed = 1'b0;
    end else begin
      cur = sites[it.site_y * cisu_pkg::LatticeSide + it.site_x];
      nxt = cur;
      // radius 0 acts as 1 and 3 as 2
      rad = (radius_bits < 2'd1) ? 1 : (radius_bits > 2'd2) ? 2 : int'(radius_bits);
      pick = int'(it.neighbour_pick);
      if (pick > 4 * rad * (rad + 1) - 1) pick = 4 * rad * (rad + 1) - 1;
      idx = 0; spin_sum = 0; picked = cisu_pkg::SiteEmpty;
      // column offset outer, row offset inner, centre skipped
      for (int i = -rad; i <= rad; i++) begin
        for (int j = -rad; j <= rad; j++) begin
          if (i == 0 && j == 0) continue;
          v = sites[((it.site_y + j + cisu_pkg::LatticeSide) % cisu_pkg::LatticeSide)
                    * cisu_pkg::LatticeSide
                    + (it.site_x + i + cisu_pkg::LatticeSide) % cisu_pkg::LatticeSide];
          if (idx == pick) picked = v;
          if (v == cisu_pkg::SiteUp) spin_sum++;
          else if (v == cisu_pkg::SiteDown) spin_sum--;
          idx++;
        end
      end
      if (cur == cisu_pkg::SiteEmpty) begin
        if (it.draw_birth < birth_p && picked != cisu_pkg::SiteEmpty) begin
          nxt = picked;
          occ_n++;
          if (picked == cisu_pkg::SiteUp) up_n++;
          if (picked == cisu_pkg::SiteDown) down_n++;
        end
      end else if (cur == cisu_pkg::SiteOcc) begin
        if (it.draw_death < death_p) begin
          nxt = cisu_pkg::SiteEmpty;
          occ_n--;
        end else if (it.draw_differentiate < diff_p) begin
          if (!it.spin_choice) begin nxt = cisu_pkg::SiteUp; up_n++; end
          else begin nxt = cisu_pkg::SiteDown; down_n++; end
        end
      end else if (it.draw_death < death_p) begin
        nxt = cisu_pkg::SiteEmpty;
        occ_n--;
        if (cur == cisu_pkg::SiteUp) up_n--;
        else down_n--;
      end else begin
        // coupling pattern 2 acts as -1
        jc = (coupling_bits == 2'd0) ? 0 : (coupling_bits == 2'd1) ? 1 : -1;
        s = (cur == cisu_pkg::SiteUp) ? 1 : -1;
        e = jc * s * spin_sum;
        if (e > 0) flip = 1'b1;
        else begin
          p = longint'(cisu_pkg::QOne);
          for (k = 0; k < -e; k++) p = (p * longint'(ratio)) >> 16;
          flip = it.draw_flip < p;
        end
        if (flip) begin
          if (cur == cisu_pkg::SiteUp) begin
            nxt = cisu_pkg::SiteDown; up_n--; down_n++;
          end else begin
            nxt = cisu_pkg::SiteUp; down_n--; up_n++;
          end
        end
      end
      sites[it.site_y * cisu_pkg::LatticeSide + it.site_x] = nxt;
      res.new_site_state = nxt;
      res.site_changed = (nxt != cur);
    end
    res.occupied_total = occ_n;
    res.up_total = up_n;
    res.down_total = down_n;
    expected_q.push_back(res);
  endfunction

  function void check_result(cisu_pkg::item_out_t got);
    cisu_pkg::item_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.new_site_state !== want.new_site_state || got.site_changed !== want.site_changed
        || got.occupied_total !== want.occupied_total || got.up_total !== want.up_total
        || got.down_total !== want.down_total) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
    end
  endfunction
endclass

module tb_top;
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cisu_pkg::item_in_t  item_i = '0;
  logic                valid_o;
  cisu_pkg::item_out_t result_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  site_ledger ledger = new();
  int  stall_cycles = 0;
  bit  quiet = 1'b0;       // no idling during the quiet stretch

  contact_ising_site_update dut (.*);

  always #5 clk_i = ~clk_i;

  // results cannot be held off, so every strobe is a beat
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) ledger.check_result(result_o);
  end

  // watchdog: fails when no start is taken and no strobe is seen, with room for a clearing pass
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 300000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // two-phase apb write; register lands on the access edge
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ledger.set_reg(idx, val);
  endtask

  // start stays high across back-to-back beats; drops only for an idle gap
  task automatic send_cmd(cisu_pkg::item_in_t it);
    item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (!(start && !busy));
    ledger.note_item(it);
    if (!quiet && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (ledger.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cisu_pkg::item_in_t mk(bit c, int x, int y, int pk, int db, int dd,
                                            int dv, bit ch, int df);
    cisu_pkg::item_in_t it;
    it.cmd = c; it.site_x = 8'(x); it.site_y = 8'(y); it.neighbour_pick = 5'(pk);
    it.draw_birth = 16'(db); it.draw_death = 16'(dd); it.draw_differentiate = 16'(dv);
    it.spin_choice = ch; it.draw_flip = 16'(df);
    return it;
  endfunction

  function automatic cisu_pkg::item_in_t rand_update();
    cisu_pkg::item_in_t it;
    it = mk(1'b0, 0, 0, $urandom_range(0, 31), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
            $urandom_range(0, 65535));
    // mostly near the seed so the colony grows and spins meet
    if ($urandom_range(0, 9) != 0) begin
      it.site_x = 8'(128 + $urandom_range(0, 12) - 6);
      it.site_y = 8'(128 + $urandom_range(0, 12) - 6);
    end else begin
      it.site_x = 8'($urandom_range(0, 255));
      it.site_y = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // birth, death, differentiation, ratio, coupling bits, radius per phase
  int phase_cfg [8][6] = '{
    '{65536, 3000, 20000, 30000, 3, 1}, '{40000, 0, 65536, 65535, 1, 2},
    '{65536, 65536, 0, 0, 0, 3},        '{0, 1000, 30000, 50000, 2, 0},
    '{65536, 2000, 10000, 20000, 3, 2}, '{50000, 5000, 40000, 60000, 1, 1},
    '{65536, 0, 0, 65535, 2, 2},        '{30000, 8000, 30000, 10000, 3, 3}};

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: seed, grow, differentiate, flip, clamped pick, lattice corners
    send_cmd(mk(1'b1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(1'b0, 129, 128, 1, 0, 0, 65535, 0, 0));
    send_cmd(mk(1'b0, 128, 128, 0, 65535, 65535, 0, 0, 65535));
    send_cmd(mk(1'b0, 129, 128, 0, 0, 65535, 0, 1, 0));
    send_cmd(mk(1'b0, 128, 128, 0, 0, 65535, 65535, 0, 65535));
    send_cmd(mk(1'b0, 129, 128, 0, 0, 65535, 65535, 1, 0));
    send_cmd(mk(1'b0, 127, 128, 31, 0, 0, 0, 0, 0));
    send_cmd(mk(1'b0, 127, 128, 2, 0, 0, 0, 0, 0));
    send_cmd(mk(1'b0, 0, 0, 23, 0, 0, 0, 0, 0));
    send_cmd(mk(1'b0, 255, 255, 0, 65535, 65535, 65535, 1, 65535));
    drain();
    reg_write(cisu_pkg::RegDeath, 65536);
    reg_write(cisu_pkg::RegRadius, 2);
    send_cmd(mk(1'b0, 128, 128, 5, 0, 65535, 0, 0, 0));
    send_cmd(mk(1'b0, 127, 128, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(1'b0, 129, 128, 24, 0, 0, 0, 0, 0));
    drain();

    // random phases, lattice reseeded now and then
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 6; r++) reg_write(3'(r), phase_cfg[ph][r]);
      quiet = (ph == 4);
      if (ph % 3 == 0) send_cmd(mk(1'b1, 0, 0, 0, 0, 0, 0, 0, 0));
      repeat (192) send_cmd(rand_update());
      drain();
    end
    quiet = 1'b0;

    repeat (40) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/cisu_pkg.sv
rtl/contact_ising_site_update.sv
rtl/cisu_checker.sv
verif/tb_top.sv
